// File: rtl/core/drive_power_state_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// Drive power state sequencer: assertion macros
// Concurrent checks on the rising clock, with reset disabling them.
// ----------------------------------------------------------------------------
`ifndef DRIVE_POWER_STATE_SEQUENCER_TOP_MACROS_SVH
`define DRIVE_POWER_STATE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication check
`define DPSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define DPSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dpss_pkg.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer package
// Drive count, status patterns, control word masks and sequence codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpss_pkg;

    // Number of drives served; drive index port is 2 bits wide
    localparam int DRIVE_COUNT = 4;
    localparam int DRIVE_IDX_W = 2;

    // Status word decoding
    localparam logic [15:0] STATUS_MASK      = 16'h1BFF;
    localparam logic [15:0] STATUS_NR_PAT_A  = 16'h02E0;
    localparam logic [15:0] STATUS_NR_PAT_B  = 16'h0260;
    localparam logic [15:0] STATUS_NR_PAT_C  = 16'h0240;
    localparam logic [15:0] STATUS_SOD_PAT   = 16'h0221;
    localparam logic [15:0] STATUS_RDY_PAT   = 16'h0233;
    localparam int          STATUS_FAULT_BIT = 3;

    // Control word edits
    localparam logic [15:0] CW_CLR_NOTREADY = 16'h0082;
    localparam logic [15:0] CW_CLR_SODIS    = 16'h0081;
    localparam logic [15:0] CW_SET_SODIS    = 16'h0006;
    localparam logic [15:0] CW_CLR_READY    = 16'h0088;
    localparam logic [15:0] CW_SET_READY    = 16'h0007;
    localparam logic [15:0] CW_CLR_SWON     = 16'h0080;
    localparam logic [15:0] CW_SET_SWON     = 16'h000F;
    localparam logic [15:0] CW_FAULT_ACK    = 16'h0080;
    localparam logic [15:0] CW_ENC_BIT      = 16'h4000;
    localparam int          CW_ENC_BIT_POS  = 14;

    // Per-drive sequence codes
    typedef enum logic [2:0] {
        ST_FAULT     = 3'd0,
        ST_NOTREADY  = 3'd1,
        ST_SODISABLE = 3'd2,
        ST_READY     = 3'd3,
        ST_SWON      = 3'd4
    } t_seq_state;

endpackage

// File: rtl/core/drive_power_state_sequencer_top.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer
// Steps each drive through the power-up sequence from its status word and
// returns the control word to send back, one item per status report.
// ----------------------------------------------------------------------------
// Each accepted item goes through two register stages: an input register,
// then the result register, which holds the result offered downstream. One
// item is taken every cycle while input stall is low; the only limit is the
// result register, and input stall rises only when both stages hold an item
// and the downstream side stalls. Sequence state and control word of every
// drive sit in flip-flops, cleared by reset to fault and zero, and are
// updated at the edge where an item moves into the result register, so a
// report for the same drive in the next cycle already sees the new values.
`timescale 1ns / 1ps

module drive_power_state_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Status report channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_drive_index,
    input  logic [15:0] i_status_word,
    input  logic        i_restart_request,
    // Control word channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_control_word,
    output logic [2:0]  o_sequence_state
);

    // Input stage
    logic                             r_s1_v;
    logic [dpss_pkg::DRIVE_IDX_W-1:0] r_idx;
    logic [15:0]                      r_status;
    logic                             r_restart;

    // Result stage
    logic        r_out_v;
    logic [15:0] r_out_cw;
    logic [2:0]  r_out_state;

    // Per-drive storage
    dpss_pkg::t_seq_state r_drive_state [dpss_pkg::DRIVE_COUNT];
    logic [15:0]          r_drive_ctrl  [dpss_pkg::DRIVE_COUNT];

    logic                 adv;
    logic                 s1_fire;
    logic                 in_range;
    logic [15:0]          n_cw;
    dpss_pkg::t_seq_state n_state;

    // Flow control: result register frees up when empty or being taken
    assign adv     = !r_out_v || !i_stall;
    assign s1_fire = r_s1_v && adv;
    assign o_stall = r_s1_v && !adv;

    assign in_range = (int'(r_idx) < dpss_pkg::DRIVE_COUNT);

    // Sequence step for the item in the input stage
    always_comb begin
        logic [15:0]          masked;
        logic                 fault;
        dpss_pkg::t_seq_state st;
        logic [15:0]          cw;

        masked = r_status & dpss_pkg::STATUS_MASK;
        fault  = r_status[dpss_pkg::STATUS_FAULT_BIT];
        st     = r_drive_state[r_idx];
        cw     = r_drive_ctrl[r_idx];

        if (r_restart) begin
            st = dpss_pkg::ST_NOTREADY;
        end
        if (fault) begin
            st = dpss_pkg::ST_FAULT;
        end

        unique case (st)
            dpss_pkg::ST_NOTREADY: begin
                cw = cw & ~dpss_pkg::CW_CLR_NOTREADY;
                if (masked == dpss_pkg::STATUS_NR_PAT_A ||
                    masked == dpss_pkg::STATUS_NR_PAT_B ||
                    masked == dpss_pkg::STATUS_NR_PAT_C) begin
                    st = dpss_pkg::ST_SODISABLE;
                end
            end
            dpss_pkg::ST_SODISABLE: begin
                cw = (cw & ~dpss_pkg::CW_CLR_SODIS) | dpss_pkg::CW_SET_SODIS;
                if (masked == dpss_pkg::STATUS_SOD_PAT) begin
                    st = dpss_pkg::ST_READY;
                end
            end
            dpss_pkg::ST_READY: begin
                cw = (cw & ~dpss_pkg::CW_CLR_READY) | dpss_pkg::CW_SET_READY;
                if (masked == dpss_pkg::STATUS_RDY_PAT) begin
                    st = dpss_pkg::ST_SWON;
                end
            end
            dpss_pkg::ST_SWON: begin
                cw = (cw & ~dpss_pkg::CW_CLR_SWON) | dpss_pkg::CW_SET_SWON;
            end
            default: begin
                // Fault: leave once the fault bit drops, else toggle acknowledge
                if (!fault) begin
                    st = dpss_pkg::ST_NOTREADY;
                end else begin
                    st = dpss_pkg::ST_FAULT;
                    cw = cw ^ dpss_pkg::CW_FAULT_ACK;
                end
            end
        endcase

        n_cw    = cw | dpss_pkg::CW_ENC_BIT;
        n_state = st;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (!o_stall) begin
            r_s1_v <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_idx     <= i_drive_index;
            r_status  <= i_status_word;
            r_restart <= i_restart_request;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_s1_v;
        end
        if (s1_fire) begin
            if (in_range) begin
                r_out_cw    <= n_cw;
                r_out_state <= n_state;
            end else begin
                r_out_cw    <= '0;
                r_out_state <= dpss_pkg::ST_FAULT;
            end
        end
    end

    // Per-drive state and control word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dpss_pkg::DRIVE_COUNT; k++) begin
                r_drive_state[k] <= dpss_pkg::ST_FAULT;
                r_drive_ctrl[k]  <= '0;
            end
        end else if (s1_fire && in_range) begin
            r_drive_state[r_idx] <= n_state;
            r_drive_ctrl[r_idx]  <= n_cw;
        end
    end

    assign o_valid          = r_out_v;
    assign o_control_word   = r_out_cw;
    assign o_sequence_state = r_out_state;

    // Checks
`include "drive_power_state_sequencer_top_macros.svh"

    `DPSS_ASSERT_NOW(a_stall_only_when_full, o_stall, r_s1_v && r_out_v && i_stall, "input stalled while a stage is free")
    `DPSS_ASSERT_NOW(a_enc_bit_set, o_valid, o_control_word[dpss_pkg::CW_ENC_BIT_POS] || o_control_word == 16'h0000, "encoder bit missing from control word")
    `DPSS_ASSERT_NEXT(a_store_matches_result, s1_fire && in_range, r_drive_state[$past(r_idx)] == r_out_state && r_drive_ctrl[$past(r_idx)] == r_out_cw, "stored drive state differs from result")

endmodule

// File: tb/drive_power_state_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer testbench
// Sends status reports for all four drives, first a walk through the power-up
// sequence, restart and fault handling, then random power-up runs mixed with
// raw noise, under changing sender gaps and receiver stalls. A scoreboard
// tracks every drive's sequence state and control word and checks each
// returned item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_power_state_sequencer_top_test;

    localparam logic [15:0] FAULT_FLAG       = 16'h0001 << dpss_pkg::STATUS_FAULT_BIT;
    localparam int          LONG_HOLD_CYCLES = 150;
    localparam int          DRAIN_LIMIT      = 2000;
    localparam int          DRAIN_TAIL       = 8;

    // Expected reply for one status report
    typedef struct packed {
        logic [15:0]          word;
        dpss_pkg::t_seq_state state;
    } t_drive_reply;

    // Per-drive sequence tracking and in-order reply check
    class seq_scoreboard;
        dpss_pkg::t_seq_state seq_state  [dpss_pkg::DRIVE_COUNT];
        logic [15:0]          drive_ctrl [dpss_pkg::DRIVE_COUNT];
        t_drive_reply         pending_replies [$];
        int                   mismatches;
        int                   checked;
        int                   swon_entries;
        int                   fault_acks;

        function new();
            for (int k = 0; k < dpss_pkg::DRIVE_COUNT; k++) begin
                seq_state[k]  = dpss_pkg::ST_FAULT;
                drive_ctrl[k] = '0;
            end
            mismatches   = 0;
            checked      = 0;
            swon_entries = 0;
            fault_acks   = 0;
        endfunction

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            mismatches++;
        endtask

        // Step one drive's sequence and queue the reply it must produce
        function void note_report(logic [1:0] idx, logic [15:0] status, logic restart);
            logic [15:0]          masked;
            logic [15:0]          cw;
            dpss_pkg::t_seq_state st;
            t_drive_reply         reply;
            masked = status & dpss_pkg::STATUS_MASK;
            st     = seq_state[idx];
            cw     = drive_ctrl[idx];
            // restart first, fault bit overrides it
            if (restart)
                st = dpss_pkg::ST_NOTREADY;
            if (status[dpss_pkg::STATUS_FAULT_BIT])
                st = dpss_pkg::ST_FAULT;
            case (st)
                dpss_pkg::ST_NOTREADY: begin
                    cw = cw & ~dpss_pkg::CW_CLR_NOTREADY;
                    if (masked == dpss_pkg::STATUS_NR_PAT_A ||
                        masked == dpss_pkg::STATUS_NR_PAT_B ||
                        masked == dpss_pkg::STATUS_NR_PAT_C)
                        st = dpss_pkg::ST_SODISABLE;
                end
                dpss_pkg::ST_SODISABLE: begin
                    cw = (cw & ~dpss_pkg::CW_CLR_SODIS) | dpss_pkg::CW_SET_SODIS;
                    if (masked == dpss_pkg::STATUS_SOD_PAT)
                        st = dpss_pkg::ST_READY;
                end
                dpss_pkg::ST_READY: begin
                    cw = (cw & ~dpss_pkg::CW_CLR_READY) | dpss_pkg::CW_SET_READY;
                    if (masked == dpss_pkg::STATUS_RDY_PAT) begin
                        st = dpss_pkg::ST_SWON;
                        swon_entries++;
                    end
                end
                dpss_pkg::ST_SWON: cw = (cw & ~dpss_pkg::CW_CLR_SWON) | dpss_pkg::CW_SET_SWON;
                default: begin
                    // fault: leave once the fault bit drops, else toggle ack
                    if (!status[dpss_pkg::STATUS_FAULT_BIT]) begin
                        st = dpss_pkg::ST_NOTREADY;
                    end else begin
                        cw = cw ^ dpss_pkg::CW_FAULT_ACK;
                        fault_acks++;
                    end
                end
            endcase
            cw = cw | dpss_pkg::CW_ENC_BIT;
            seq_state[idx]  = st;
            drive_ctrl[idx] = cw;
            reply.word  = cw;
            reply.state = st;
            pending_replies.push_back(reply);
        endfunction

        task check_reply(logic [15:0] word, logic [2:0] state);
            t_drive_reply exp_reply;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected item cw=%h state=%0d", word, state));
            end else begin
                exp_reply = pending_replies.pop_front();
                checked++;
                if (word !== exp_reply.word || state !== exp_reply.state)
                    report_mismatch($sformatf("item %0d: cw=%h state=%0d, expected cw=%h state=%0d",
                        checked, word, state, exp_reply.word, exp_reply.state));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_drive_index;
    logic [15:0] i_status_word;
    logic        i_restart_request;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_control_word;
    logic [2:0]  o_sequence_state;

    seq_scoreboard sb;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            items_sent    = 0;
    bit            hold_req      = 1'b0;

    drive_power_state_sequencer_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_drive_index     (i_drive_index),
        .i_status_word     (i_status_word),
        .i_restart_request (i_restart_request),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_control_word    (o_control_word),
        .o_sequence_state  (o_sequence_state)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_400_000;
        $display("Timeout: run did not finish");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Monitor both channels at the edge where items move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_reply(o_control_word, o_sequence_state);
            if (i_valid && !o_stall)
                sb.note_report(i_drive_index, i_status_word, i_restart_request);
        end
    end

    // Offer one status report, after a random gap, and hold it until taken
    task automatic send_report(input logic [1:0] idx, input logic [15:0] status,
                               input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_drive_index     <= idx;
        i_status_word     <= status;
        i_restart_request <= restart;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Random bits that the status mask throws away
    function automatic logic [15:0] masked_junk();
        return 16'($urandom) & ~dpss_pkg::STATUS_MASK;
    endfunction

    // One power-up run for a drive, with steps occasionally dropped
    task automatic power_up_sequence(input logic [1:0] idx);
        logic [15:0] nr_pat;
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(1, 3))
                send_report(idx, 16'($urandom) | FAULT_FLAG, 1'($urandom_range(1)));
        end
        send_report(idx, 16'($urandom) & ~FAULT_FLAG, 1'b1);
        case ($urandom_range(2))
            0: nr_pat = dpss_pkg::STATUS_NR_PAT_A;
            1: nr_pat = dpss_pkg::STATUS_NR_PAT_B;
            default: nr_pat = dpss_pkg::STATUS_NR_PAT_C;
        endcase
        if ($urandom_range(99) < 92)
            send_report(idx, nr_pat | masked_junk(), 1'b0);
        if ($urandom_range(99) < 30)
            send_report(idx, 16'($urandom) & ~FAULT_FLAG, 1'b0);
        if ($urandom_range(99) < 92)
            send_report(idx, dpss_pkg::STATUS_SOD_PAT | masked_junk(), 1'b0);
        if ($urandom_range(99) < 92)
            send_report(idx, dpss_pkg::STATUS_RDY_PAT | masked_junk(), 1'b0);
        repeat ($urandom_range(1, 3))
            send_report(idx, 16'($urandom) & ~FAULT_FLAG, 1'b0);
    endtask

    // Mostly power-up runs, the rest raw reports on any drive
    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                power_up_sequence(2'($urandom_range(3)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_report(2'($urandom_range(3)), 16'($urandom_range(65535)),
                                1'($urandom_range(1)));
            end
        end
    endtask

    // Main sequence
    initial begin
        int drain_wait;
        sb = new();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_drive_index     <= '0;
        i_status_word     <= '0;
        i_restart_request <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drive 0: out of fault, full power-up, then fault and acknowledge
        send_report(2'd0, 16'h0000, 1'b0);
        send_report(2'd0, 16'h0240, 1'b0);
        send_report(2'd0, 16'h0221, 1'b0);
        send_report(2'd0, 16'h0233, 1'b0);
        send_report(2'd0, 16'hFFF7, 1'b0);
        send_report(2'd0, 16'hFFFF, 1'b0);
        send_report(2'd0, 16'h0008, 1'b0);
        // fault bit wins over restart
        send_report(2'd0, 16'h0008, 1'b1);
        send_report(2'd0, 16'h0000, 1'b1);
        // Drive 1: patterns with masked-off bits set, near misses, restart
        send_report(2'd1, 16'h0000, 1'b1);
        send_report(2'd1, 16'hC6E0, 1'b0);
        send_report(2'd1, 16'h0220, 1'b0);
        send_report(2'd1, 16'hE621, 1'b0);
        send_report(2'd1, 16'h0232, 1'b0);
        send_report(2'd1, 16'h0233, 1'b1);
        // Drive 2: second not-ready pattern, restart out of switch-on disabled
        send_report(2'd2, 16'h0000, 1'b0);
        send_report(2'd2, 16'h0260, 1'b0);
        send_report(2'd2, 16'h0221, 1'b1);
        // Drive 3: fault straight from reset, then full sequence and restart
        send_report(2'd3, 16'hFFFF, 1'b1);
        send_report(2'd3, 16'hFFF7, 1'b0);
        send_report(2'd3, 16'h02E0, 1'b0);
        send_report(2'd3, 16'h0221, 1'b0);
        send_report(2'd3, 16'h0233, 1'b0);
        send_report(2'd3, 16'h0000, 1'b1);

        // Random phases under different gap and stall mixes
        run_random(170);
        send_idle_pct = 71;
        run_random(170);
        send_idle_pct = 0;
        stall_pct     = 71;
        run_random(170);
        send_idle_pct = 29;
        stall_pct     = 29;
        run_random(170);
        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        run_random(170);

        i_valid <= 1'b0;
        drain_wait = 0;
        while (sb.pending_replies.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.pending_replies.size() != 0)
            sb.report_mismatch($sformatf("%0d replies never arrived",
                sb.pending_replies.size()));

        $display("Covered %0d status reports on %0d drives, %0d replies checked",
            items_sent, dpss_pkg::DRIVE_COUNT, sb.checked);
        $display("  %0d switch-on entries, %0d fault ack toggles, %0d-cycle receiver hold",
            sb.swon_entries, sb.fault_acks, LONG_HOLD_CYCLES);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
